// ===== hdl/battery_alert_monitor_core_defines.svh =====
// Assertion macros shared by the battery alert monitor RTL.
`ifndef BATTERY_ALERT_MONITOR_CORE_DEFINES_SVH
`define BATTERY_ALERT_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BAM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("battery alert monitor assertion failed");

// Next-cycle implication, checked outside reset.
`define BAM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("battery alert monitor assertion failed");

`endif

// ===== hdl/bam_pkg.sv =====
// Types and constants of the battery alert monitor.
`timescale 1ns / 1ps

package bam_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_SCALE,
    ST_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    ALERT_NONE     = 3'd0,
    ALERT_STATE    = 3'd1,
    ALERT_CRITICAL = 3'd2,
    ALERT_LOW      = 3'd3,
    ALERT_FULL     = 3'd4
  } alert_t;

  localparam logic        REG_WARNING  = 1'b0;
  localparam logic        REG_CRITICAL = 1'b1;

  localparam logic [2:0]  CHG_STEADY   = 3'd0;
  localparam logic [15:0] TICK_MAX     = 16'hFFFF;
  localparam logic [21:0] RATE_MAX     = 22'h3FFFFF;
  localparam logic [21:0] RATE_RESET   = 22'd100;

endpackage

// ===== hdl/battery_alert_monitor_core.sv =====
// Battery alert monitor: per-sample alert sequencer with a serial rate divider.
//
// One sample beat enters on the in_ channel (valid/stall) and one result beat
// leaves on the out_ channel. in_stall is high while a sample is being worked.
// A sample whose capacity changed while the rate is unknown runs a restoring
// divider, one quotient bit per cycle, and passes through ST_CALC, ST_DIV,
// ST_SCALE and ST_OUT; any other sample goes from ST_CALC to ST_OUT. The
// divider has a single compare-and-subtract step.
// The result sits in an output register, so a stalled receiver holds the
// result steady; the next sample is accepted and worked meanwhile and waits
// in its final step until the output register frees up.
// Registers warning_level (byte address 0) and critical_level (address 4) are
// written over the cfg_ APB-style port. The user must write them only while
// the block is idle; the block itself does not enforce this.
// Synchronous reset clears the levels, the capacity and state history, the
// tick count and both latches, and sets the rate estimate to 100.
`timescale 1ns / 1ps
`include "battery_alert_monitor_core_defines.svh"

module battery_alert_monitor_core #(
  parameter int CAP_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_charge_state,
  input  logic                in_rate_unknown,
  input  logic [15:0]         in_measured_rate,
  input  logic [CAP_BITS-1:0] in_remaining_mah,
  input  logic [15:0]         in_voltage_mv,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_alert,
  output logic [2:0]          out_state_out,
  output logic [21:0]         out_rate_out,
  output logic [15:0]         out_remaining_out,
  output logic [15:0]         out_voltage_out,

  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int CW    = (CAP_BITS > 16) ? CAP_BITS : 16;
  localparam int PW    = (CAP_BITS + 6 > 22) ? CAP_BITS + 6 : 23;
  localparam int CNT_W = $clog2(CAP_BITS);

  bam_pkg::seq_state_t state_r, state_nxt;

  logic [15:0]          warn_r, warn_nxt;
  logic [15:0]          crit_r, crit_nxt;

  logic [CAP_BITS-1:0]  last_cap_r, last_cap_nxt;
  logic [2:0]           last_state_r, last_state_nxt;
  logic [15:0]          ticks_r, ticks_nxt;
  logic                 low_r, low_nxt;
  logic                 full_r, full_nxt;
  logic [21:0]          rate_est_r, rate_est_nxt;

  logic [2:0]           it_state_r, it_state_nxt;
  logic                 it_unknown_r, it_unknown_nxt;
  logic [15:0]          it_meas_r, it_meas_nxt;
  logic [CAP_BITS-1:0]  it_rem_r, it_rem_nxt;
  logic [15:0]          it_volt_r, it_volt_nxt;

  logic [15:0]          div_rem_r, div_rem_nxt;
  logic [CAP_BITS-1:0]  div_quo_r, div_quo_nxt;
  logic [15:0]          div_den_r, div_den_nxt;
  logic [CNT_W-1:0]     div_cnt_r, div_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  bam_pkg::alert_t      out_alert_r, out_alert_nxt;
  logic [2:0]           out_state_r, out_state_nxt;
  logic [21:0]          out_rate_r, out_rate_nxt;
  logic [15:0]          out_rem_r, out_rem_nxt;
  logic [15:0]          out_volt_r, out_volt_nxt;

  logic                 in_accept;
  logic                 cfg_write;
  logic                 out_load;
  logic [15:0]          ticks_inc;
  logic [CAP_BITS-1:0]  last_eff;
  logic [CAP_BITS-1:0]  cap_diff;
  logic [16:0]          div_trial;
  logic                 div_fit;
  logic [PW-1:0]        quo_x;
  logic [PW-1:0]        scaled;
  logic [CW-1:0]        rem_x;
  logic [CW-1:0]        warn_x;
  logic [CW-1:0]        crit_x;
  bam_pkg::alert_t      alert_sel;
  logic                 low_sel;
  logic                 full_sel;

  assign in_stall   = (state_r != bam_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == bam_pkg::REG_CRITICAL) ? {16'd0, crit_r}
                                                              : {16'd0, warn_r};
  assign out_load   = (state_r == bam_pkg::ST_OUT) && (!out_valid_r || !out_stall);

  assign ticks_inc  = (ticks_r == bam_pkg::TICK_MAX) ? ticks_r : ticks_r + 16'd1;
  assign last_eff   = (last_cap_r == '0) ? it_rem_r : last_cap_r;
  assign cap_diff   = (last_eff > it_rem_r) ? last_eff - it_rem_r : it_rem_r - last_eff;

  assign div_trial  = {div_rem_r, div_quo_r[CAP_BITS-1]};
  assign div_fit    = (div_trial >= {1'b0, div_den_r});

  assign quo_x      = PW'(div_quo_r);
  assign scaled     = (quo_x << 6) - (quo_x << 2);

  assign rem_x      = CW'(it_rem_r);
  assign warn_x     = CW'(warn_r);
  assign crit_x     = CW'(crit_r);

  always_comb begin
    alert_sel = bam_pkg::ALERT_NONE;
    low_sel   = low_r;
    full_sel  = full_r;
    priority if (it_state_r != last_state_r) begin
      alert_sel = bam_pkg::ALERT_STATE;
    end else if (rem_x <= crit_x) begin
      alert_sel = bam_pkg::ALERT_CRITICAL;
    end else if (rem_x <= warn_x && !low_r) begin
      alert_sel = bam_pkg::ALERT_LOW;
      low_sel   = 1'b1;
    end else if (it_state_r == bam_pkg::CHG_STEADY && !full_r) begin
      alert_sel = bam_pkg::ALERT_FULL;
      full_sel  = 1'b1;
    end else if (rem_x > warn_x && low_r) begin
      low_sel   = 1'b0;
    end else if (full_r && it_state_r != bam_pkg::CHG_STEADY) begin
      full_sel  = 1'b0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    warn_nxt       = warn_r;
    crit_nxt       = crit_r;
    last_cap_nxt   = last_cap_r;
    last_state_nxt = last_state_r;
    ticks_nxt      = ticks_r;
    low_nxt        = low_r;
    full_nxt       = full_r;
    rate_est_nxt   = rate_est_r;
    it_state_nxt   = it_state_r;
    it_unknown_nxt = it_unknown_r;
    it_meas_nxt    = it_meas_r;
    it_rem_nxt     = it_rem_r;
    it_volt_nxt    = it_volt_r;
    div_rem_nxt    = div_rem_r;
    div_quo_nxt    = div_quo_r;
    div_den_nxt    = div_den_r;
    div_cnt_nxt    = div_cnt_r;
    out_valid_nxt  = out_valid_r;
    out_alert_nxt  = out_alert_r;
    out_state_nxt  = out_state_r;
    out_rate_nxt   = out_rate_r;
    out_rem_nxt    = out_rem_r;
    out_volt_nxt   = out_volt_r;

    if (cfg_write) begin
      if (cfg_paddr[2] == bam_pkg::REG_CRITICAL) begin
        crit_nxt = cfg_pwdata[15:0];
      end else begin
        warn_nxt = cfg_pwdata[15:0];
      end
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      bam_pkg::ST_IDLE: begin
        if (in_accept) begin
          it_state_nxt   = in_charge_state;
          it_unknown_nxt = in_rate_unknown;
          it_meas_nxt    = in_measured_rate;
          it_rem_nxt     = in_remaining_mah;
          it_volt_nxt    = in_voltage_mv;
          state_nxt      = bam_pkg::ST_CALC;
        end
      end
      bam_pkg::ST_CALC: begin
        last_cap_nxt = it_rem_r;
        if (last_eff != it_rem_r) begin
          ticks_nxt = 16'd0;
          if (it_unknown_r) begin
            div_rem_nxt = 16'd0;
            div_quo_nxt = cap_diff;
            div_den_nxt = ticks_inc;
            div_cnt_nxt = CNT_W'(CAP_BITS - 1);
            state_nxt   = bam_pkg::ST_DIV;
          end else begin
            state_nxt   = bam_pkg::ST_OUT;
          end
        end else begin
          ticks_nxt = ticks_inc;
          state_nxt = bam_pkg::ST_OUT;
        end
      end
      bam_pkg::ST_DIV: begin
        div_rem_nxt = div_fit ? 16'(div_trial - {1'b0, div_den_r}) : div_trial[15:0];
        div_quo_nxt = {div_quo_r[CAP_BITS-2:0], div_fit};
        div_cnt_nxt = div_cnt_r - CNT_W'(1);
        if (div_cnt_r == '0) begin
          state_nxt = bam_pkg::ST_SCALE;
        end
      end
      bam_pkg::ST_SCALE: begin
        rate_est_nxt = (scaled > PW'(bam_pkg::RATE_MAX)) ? bam_pkg::RATE_MAX : scaled[21:0];
        state_nxt    = bam_pkg::ST_OUT;
      end
      bam_pkg::ST_OUT: begin
        if (out_load) begin
          low_nxt        = low_sel;
          full_nxt       = full_sel;
          last_state_nxt = it_state_r;
          out_valid_nxt  = 1'b1;
          out_alert_nxt  = alert_sel;
          out_state_nxt  = it_state_r;
          out_rate_nxt   = it_unknown_r ? rate_est_r : {6'd0, it_meas_r};
          out_rem_nxt    = rem_x[15:0];
          out_volt_nxt   = it_volt_r;
          state_nxt      = bam_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bam_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bam_pkg::ST_IDLE;
      warn_r       <= 16'd0;
      crit_r       <= 16'd0;
      last_cap_r   <= '0;
      last_state_r <= 3'd0;
      ticks_r      <= 16'd0;
      low_r        <= 1'b0;
      full_r       <= 1'b0;
      rate_est_r   <= bam_pkg::RATE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      warn_r       <= warn_nxt;
      crit_r       <= crit_nxt;
      last_cap_r   <= last_cap_nxt;
      last_state_r <= last_state_nxt;
      ticks_r      <= ticks_nxt;
      low_r        <= low_nxt;
      full_r       <= full_nxt;
      rate_est_r   <= rate_est_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_state_r   <= it_state_nxt;
    it_unknown_r <= it_unknown_nxt;
    it_meas_r    <= it_meas_nxt;
    it_rem_r     <= it_rem_nxt;
    it_volt_r    <= it_volt_nxt;
    div_rem_r    <= div_rem_nxt;
    div_quo_r    <= div_quo_nxt;
    div_den_r    <= div_den_nxt;
    div_cnt_r    <= div_cnt_nxt;
    out_alert_r  <= out_alert_nxt;
    out_state_r  <= out_state_nxt;
    out_rate_r   <= out_rate_nxt;
    out_rem_r    <= out_rem_nxt;
    out_volt_r   <= out_volt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_alert         = out_alert_r;
  assign out_state_out     = out_state_r;
  assign out_rate_out      = out_rate_r;
  assign out_remaining_out = out_rem_r;
  assign out_voltage_out   = out_volt_r;

  `BAM_ASSERT_NEXT(a_accept_to_calc, in_accept, state_r == bam_pkg::ST_CALC)
  `BAM_ASSERT_NOW(a_div_nonzero, state_r == bam_pkg::ST_DIV, div_den_r != 16'd0)
  `BAM_ASSERT_NEXT(a_load_to_valid, out_load, out_valid_r)
  `BAM_ASSERT_NOW(a_low_alert_latched, out_valid_r && out_alert_r == bam_pkg::ALERT_LOW, low_r)
  `BAM_ASSERT_NOW(a_full_alert_latched, out_valid_r && out_alert_r == bam_pkg::ALERT_FULL, full_r)

endmodule
